@@ rtl/nmbe_pkg.sv @@
// ----------------------------------------------------------------------------
// nmbe_pkg: shared types and constants of the NTT butterfly engine
// Command codes, configuration register indexes, reset values and the
// control bundle that the controller hands to the datapath.
// ----------------------------------------------------------------------------
package nmbe_pkg;

  typedef enum logic [2:0] {
    FUNC_LOAD_COEFF = 3'd0,
    FUNC_LOAD_FWD   = 3'd1,
    FUNC_LOAD_INV   = 3'd2,
    FUNC_FORWARD    = 3'd3,
    FUNC_INVERSE    = 3'd4,
    FUNC_READ       = 3'd5
  } func_e;

  typedef enum logic [2:0] {
    CFG_MODULUS         = 3'd0,
    CFG_MODULUS_INVERSE = 3'd1,
    CFG_RADIX_BITS      = 3'd2,
    CFG_RADIX_MASK      = 3'd3,
    CFG_LOG_POINTS      = 3'd4
  } cfg_idx_e;

  localparam logic [30:0] ModulusReset        = 31'd8380417;
  localparam logic [31:0] ModulusInverseReset = 32'd58728449;
  localparam logic [5:0]  RadixBitsReset      = 6'd32;
  localparam logic [31:0] RadixMaskReset      = 32'hFFFF_FFFF;
  localparam logic [3:0]  LogPointsReset      = 4'd8;

  typedef struct packed {
    logic [30:0] modulus;
    logic [31:0] modulus_inverse;
    logic [5:0]  radix_bits;
    logic [31:0] radix_mask;
    logic [3:0]  log_points;
  } cfg_t;

  typedef enum logic [1:0] {
    WSEL_LOAD = 2'd0,
    WSEL_HI   = 2'd1,
    WSEL_LO   = 2'd2
  } wsel_e;

  typedef struct packed {
    logic  a_en;
    logic  b_en;
    logic  zeta_en;
    logic  x_en;
    logic  u_en;
    logic  p_en;
    logic  t_en;
    logic  out_en;
    logic  out_zero;
    logic  fwd;
    logic  coeff_we;
    logic  fwd_we;
    logic  inv_we;
    wsel_e wsel;
  } dp_ctrl_t;

endpackage

@@ rtl/nmbe_if.sv @@
// ----------------------------------------------------------------------------
// nmbe_if: channel interfaces of the NTT butterfly engine
// Command, response and configuration channels with valid/ready handshake.
// ----------------------------------------------------------------------------
interface nmbe_cmd_if;
  logic               valid;
  logic               ready;
  logic [2:0]         func;
  logic [7:0]         index;
  logic signed [31:0] value;

  modport source (output valid, func, index, value, input ready);
  modport sink (input valid, func, index, value, output ready);
endinterface

interface nmbe_rsp_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] coefficient;

  modport source (output valid, coefficient, input ready);
  modport sink (input valid, coefficient, output ready);
endinterface

interface nmbe_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [31:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

@@ rtl/nmbe_ram.sv @@
// ----------------------------------------------------------------------------
// nmbe_ram: generic single-write, single-read RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module nmbe_ram #(
  parameter int Width = 32,
  parameter int Depth = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

@@ rtl/nmbe_datapath.sv @@
// ----------------------------------------------------------------------------
// nmbe_datapath: stores and Montgomery butterfly arithmetic
// Coefficient store, twiddle tables, operand registers, the reduction
// multipliers and the read-back output register.
// ----------------------------------------------------------------------------
module nmbe_datapath #(
  parameter int MaxPoints = 256
) (
  input  logic                         clk_i,
  input  nmbe_pkg::dp_ctrl_t           ctl_i,
  input  nmbe_pkg::cfg_t               cfg_i,
  input  logic [$clog2(MaxPoints)-1:0] coeff_raddr_i,
  input  logic [$clog2(MaxPoints)-1:0] coeff_waddr_i,
  input  logic [$clog2(MaxPoints)-1:0] tw_raddr_i,
  input  logic [$clog2(MaxPoints)-1:0] tw_waddr_i,
  input  logic [31:0]                  load_value_i,
  output logic [31:0]                  coefficient_o
);

  logic [31:0]        coeff_rdata, fwd_rdata, inv_rdata, coeff_wdata;
  logic [31:0]        a_q, b_q, zeta_q, u_q, t_q, out_q;
  logic signed [63:0] x_q, x_d;
  logic [62:0]        p_q, p_d;
  logic [31:0]        u_d, t_d;
  logic signed [31:0] zeta_s, op_s;
  logic signed [64:0] s_d, sh_d;

  nmbe_ram #(.Width(32), .Depth(MaxPoints)) u_coeff_ram (
    .clk_i   (clk_i),
    .we_i    (ctl_i.coeff_we),
    .waddr_i (coeff_waddr_i),
    .wdata_i (coeff_wdata),
    .raddr_i (coeff_raddr_i),
    .rdata_o (coeff_rdata)
  );

  nmbe_ram #(.Width(32), .Depth(MaxPoints)) u_fwd_ram (
    .clk_i   (clk_i),
    .we_i    (ctl_i.fwd_we),
    .waddr_i (tw_waddr_i),
    .wdata_i (load_value_i),
    .raddr_i (tw_raddr_i),
    .rdata_o (fwd_rdata)
  );

  nmbe_ram #(.Width(32), .Depth(MaxPoints)) u_inv_ram (
    .clk_i   (clk_i),
    .we_i    (ctl_i.inv_we),
    .waddr_i (tw_waddr_i),
    .wdata_i (load_value_i),
    .raddr_i (tw_raddr_i),
    .rdata_o (inv_rdata)
  );

  // Forward multiplies the upper operand, inverse multiplies the difference.
  assign zeta_s = $signed(zeta_q);
  assign op_s   = ctl_i.fwd ? $signed(b_q) : $signed(a_q - b_q);
  assign x_d    = zeta_s * op_s;
  assign u_d    = ((x_q[31:0] & cfg_i.radix_mask) * cfg_i.modulus_inverse)
                  & cfg_i.radix_mask;
  assign p_d    = 63'(u_q) * 63'(cfg_i.modulus);
  // The sum is formed exactly in 65 bits before the arithmetic shift.
  assign s_d    = $signed({x_q[63], x_q}) + $signed({2'b00, p_q});
  assign sh_d   = s_d >>> cfg_i.radix_bits;
  assign t_d    = sh_d[31:0];

  always_comb begin
    unique case (ctl_i.wsel)
      nmbe_pkg::WSEL_LOAD: coeff_wdata = load_value_i;
      nmbe_pkg::WSEL_HI:   coeff_wdata = ctl_i.fwd ? a_q + t_q : a_q + b_q;
      nmbe_pkg::WSEL_LO:   coeff_wdata = ctl_i.fwd ? a_q - t_q : t_q;
      default:             coeff_wdata = load_value_i;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.a_en) begin
      a_q <= coeff_rdata;
    end
    if (ctl_i.zeta_en) begin
      zeta_q <= ctl_i.fwd ? fwd_rdata : inv_rdata;
    end
    if (ctl_i.b_en) begin
      b_q <= coeff_rdata;
    end
    if (ctl_i.x_en) begin
      x_q <= x_d;
    end
    if (ctl_i.u_en) begin
      u_q <= u_d;
    end
    if (ctl_i.p_en) begin
      p_q <= p_d;
    end
    if (ctl_i.t_en) begin
      t_q <= t_d;
    end
    if (ctl_i.out_en) begin
      out_q <= ctl_i.out_zero ? 32'd0 : coeff_rdata;
    end
  end

  assign coefficient_o = out_q;

endmodule

@@ rtl/nmbe_controller.sv @@
// ----------------------------------------------------------------------------
// nmbe_controller: command sequencer of the NTT butterfly engine
// Decodes commands, walks the butterfly loops and steps the datapath.
// ----------------------------------------------------------------------------
module nmbe_controller #(
  parameter int MaxPoints = 256
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cmd_valid_i,
  input  logic [2:0]                   cmd_func_i,
  input  logic [7:0]                   cmd_index_i,
  output logic                         cmd_ready_o,
  input  logic                         rsp_ready_i,
  output logic                         rsp_valid_o,
  input  logic [3:0]                   log_points_i,
  output nmbe_pkg::dp_ctrl_t           ctl_o,
  output logic [$clog2(MaxPoints)-1:0] coeff_raddr_o,
  output logic [$clog2(MaxPoints)-1:0] coeff_waddr_o,
  output logic [$clog2(MaxPoints)-1:0] tw_raddr_o,
  output logic [$clog2(MaxPoints)-1:0] tw_waddr_o
);

  localparam int AW     = $clog2(MaxPoints);
  localparam int CW     = AW + 1;
  localparam int LogMax = $clog2(MaxPoints + 1) - 1;

  typedef enum logic [11:0] {
    S_IDLE = 12'b0000_0000_0001,
    S_RD1  = 12'b0000_0000_0010,
    S_RD2  = 12'b0000_0000_0100,
    S_RDA  = 12'b0000_0000_1000,
    S_RDB  = 12'b0000_0001_0000,
    S_CAPB = 12'b0000_0010_0000,
    S_MULX = 12'b0000_0100_0000,
    S_MULU = 12'b0000_1000_0000,
    S_MULP = 12'b0001_0000_0000,
    S_SUMT = 12'b0010_0000_0000,
    S_WRA  = 12'b0100_0000_0000,
    S_WRB  = 12'b1000_0000_0000
  } state_e;

  state_e          state_q, state_d;
  logic [CW-1:0]   len_q, len_d, start_q, start_d, jo_q, jo_d, n_q, n_d;
  logic [AW-1:0]   k_q, k_d;
  logic            fwd_q, fwd_d, ok_q, ok_d, out_valid_q, out_valid_d;
  logic [7:0]      idx_q, idx_d;
  logic [3:0]      lp_sat;
  logic [CW-1:0]   n_run, j_sum;
  logic [AW-1:0]   a_addr, b_addr, idx_addr, rd_addr;
  logic            ok;

  assign lp_sat   = (log_points_i > 4'(LogMax)) ? 4'(LogMax) : log_points_i;
  assign n_run    = CW'(1) << lp_sat;
  assign j_sum    = start_q + jo_q;
  assign a_addr   = AW'(j_sum);
  assign b_addr   = AW'(j_sum + len_q);
  assign idx_addr = AW'(cmd_index_i);
  assign rd_addr  = AW'(idx_q);
  assign ok       = {24'd0, cmd_index_i} < 32'(MaxPoints);

  assign cmd_ready_o = (state_q == S_IDLE);
  assign rsp_valid_o = out_valid_q;
  assign tw_raddr_o  = k_q;
  assign tw_waddr_o  = idx_addr;

  always_comb begin
    state_d       = state_q;
    len_d         = len_q;
    start_d       = start_q;
    jo_d          = jo_q;
    n_d           = n_q;
    k_d           = k_q;
    fwd_d         = fwd_q;
    ok_d          = ok_q;
    idx_d         = idx_q;
    ctl_o         = '0;
    ctl_o.wsel    = nmbe_pkg::WSEL_LOAD;
    ctl_o.fwd     = fwd_q;
    coeff_raddr_o = a_addr;
    coeff_waddr_o = idx_addr;

    unique case (state_q)
      S_IDLE: begin
        if (cmd_valid_i) begin
          case (nmbe_pkg::func_e'(cmd_func_i))
            nmbe_pkg::FUNC_LOAD_COEFF: ctl_o.coeff_we = ok;
            nmbe_pkg::FUNC_LOAD_FWD:   ctl_o.fwd_we   = ok;
            nmbe_pkg::FUNC_LOAD_INV:   ctl_o.inv_we   = ok;
            nmbe_pkg::FUNC_FORWARD: begin
              if (n_run >= CW'(2)) begin
                fwd_d   = 1'b1;
                len_d   = n_run >> 1;
                start_d = '0;
                jo_d    = '0;
                k_d     = AW'(1);
                n_d     = n_run;
                state_d = S_RDA;
              end
            end
            nmbe_pkg::FUNC_INVERSE: begin
              if (n_run >= CW'(2)) begin
                fwd_d   = 1'b0;
                len_d   = CW'(1);
                start_d = '0;
                jo_d    = '0;
                k_d     = '0;
                n_d     = n_run;
                state_d = S_RDA;
              end
            end
            nmbe_pkg::FUNC_READ: begin
              idx_d   = cmd_index_i;
              ok_d    = ok;
              state_d = S_RD1;
            end
            default: ;
          endcase
        end
      end
      S_RD1: begin
        coeff_raddr_o = rd_addr;
        state_d       = S_RD2;
      end
      S_RD2: begin
        // The address is held so the read data stays valid while the slot is full.
        coeff_raddr_o = rd_addr;
        if (!out_valid_q || rsp_ready_i) begin
          ctl_o.out_en   = 1'b1;
          ctl_o.out_zero = !ok_q;
          state_d        = S_IDLE;
        end
      end
      S_RDA: begin
        coeff_raddr_o = a_addr;
        state_d       = S_RDB;
      end
      S_RDB: begin
        coeff_raddr_o = b_addr;
        ctl_o.a_en    = 1'b1;
        ctl_o.zeta_en = 1'b1;
        state_d       = S_CAPB;
      end
      S_CAPB: begin
        ctl_o.b_en = 1'b1;
        state_d    = S_MULX;
      end
      S_MULX: begin
        ctl_o.x_en = 1'b1;
        state_d    = S_MULU;
      end
      S_MULU: begin
        ctl_o.u_en = 1'b1;
        state_d    = S_MULP;
      end
      S_MULP: begin
        ctl_o.p_en = 1'b1;
        state_d    = S_SUMT;
      end
      S_SUMT: begin
        ctl_o.t_en = 1'b1;
        state_d    = S_WRA;
      end
      S_WRA: begin
        ctl_o.coeff_we = 1'b1;
        ctl_o.wsel     = nmbe_pkg::WSEL_HI;
        coeff_waddr_o  = a_addr;
        state_d        = S_WRB;
      end
      S_WRB: begin
        ctl_o.coeff_we = 1'b1;
        ctl_o.wsel     = nmbe_pkg::WSEL_LO;
        coeff_waddr_o  = b_addr;
        state_d        = S_RDA;
        if (jo_q + CW'(1) < len_q) begin
          jo_d = jo_q + CW'(1);
        end else begin
          jo_d = '0;
          k_d  = k_q + AW'(1);
          if (start_q + (len_q << 1) < n_q) begin
            start_d = start_q + (len_q << 1);
          end else begin
            start_d = '0;
            if (fwd_q) begin
              if (len_q == CW'(1)) begin
                state_d = S_IDLE;
              end else begin
                len_d = len_q >> 1;
              end
            end else begin
              if ((len_q << 1) >= n_q) begin
                state_d = S_IDLE;
              end else begin
                len_d = len_q << 1;
              end
            end
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  assign out_valid_d = (out_valid_q && !rsp_ready_i) || ctl_o.out_en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      len_q       <= '0;
      start_q     <= '0;
      jo_q        <= '0;
      n_q         <= '0;
      k_q         <= '0;
      fwd_q       <= 1'b0;
      ok_q        <= 1'b0;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      len_q       <= len_d;
      start_q     <= start_d;
      jo_q        <= jo_d;
      n_q         <= n_d;
      k_q         <= k_d;
      fwd_q       <= fwd_d;
      ok_q        <= ok_d;
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  a_coeff_write_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_o.coeff_we |-> (state_q == S_IDLE || state_q == S_WRA || state_q == S_WRB))
    else $error("coefficient store written outside a load or butterfly write");

  a_butterfly_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_RDA) |-> (len_q != '0 && (j_sum + len_q) < n_q))
    else $error("butterfly operand address beyond the transform length");

  a_read_delivers: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_RD2 && !out_valid_q) |=> (out_valid_q && state_q == S_IDLE))
    else $error("read with a free output slot did not deliver");

endmodule

@@ rtl/ntt_montgomery_butterfly_engine.sv @@
// ----------------------------------------------------------------------------
// ntt_montgomery_butterfly_engine: in-place NTT engine with Montgomery
// butterflies
// Holds the configuration registers and joins the controller and datapath.
//
//   Port    Dir  Handshake     Carries
//   cmd_i   in   valid/ready   func, index, value
//   rsp_o   out  valid/ready   coefficient
//   cfg_i   in   valid/ready   index, data (always ready)
//
// Loads are accepted back to back and written as accepted. A read passes S_RD1
// and S_RD2 to the output register; no command is accepted until it is loaded
// there. A transform runs (n/2)*log2(n) butterflies, each through S_RDA to
// S_WRB in turn, as the coefficient RAM has a single read and write port.
// Reset clears control state only; the stores hold nothing until written.
// A stalled response holds a new read in S_RD2; loads ahead of it go through.
// ----------------------------------------------------------------------------
module ntt_montgomery_butterfly_engine #(
  parameter int MAX_POINTS = 256
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  nmbe_cmd_if.sink   cmd_i,
  nmbe_rsp_if.source rsp_o,
  nmbe_cfg_if.sink   cfg_i
);

  localparam int AW = $clog2(MAX_POINTS);

  nmbe_pkg::cfg_t     cfg_q;
  nmbe_pkg::dp_ctrl_t ctl;
  logic [AW-1:0]      coeff_raddr, coeff_waddr, tw_raddr, tw_waddr;
  logic [31:0]        coefficient;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.modulus         <= nmbe_pkg::ModulusReset;
      cfg_q.modulus_inverse <= nmbe_pkg::ModulusInverseReset;
      cfg_q.radix_bits      <= nmbe_pkg::RadixBitsReset;
      cfg_q.radix_mask      <= nmbe_pkg::RadixMaskReset;
      cfg_q.log_points      <= nmbe_pkg::LogPointsReset;
    end else if (cfg_i.valid) begin
      case (nmbe_pkg::cfg_idx_e'(cfg_i.index))
        nmbe_pkg::CFG_MODULUS:         cfg_q.modulus         <= cfg_i.data[30:0];
        nmbe_pkg::CFG_MODULUS_INVERSE: cfg_q.modulus_inverse <= cfg_i.data;
        nmbe_pkg::CFG_RADIX_BITS:      cfg_q.radix_bits      <= cfg_i.data[5:0];
        nmbe_pkg::CFG_RADIX_MASK:      cfg_q.radix_mask      <= cfg_i.data;
        nmbe_pkg::CFG_LOG_POINTS:      cfg_q.log_points      <= cfg_i.data[3:0];
        default: ;
      endcase
    end
  end

  nmbe_controller #(.MaxPoints(MAX_POINTS)) u_controller (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_valid_i   (cmd_i.valid),
    .cmd_func_i    (cmd_i.func),
    .cmd_index_i   (cmd_i.index),
    .cmd_ready_o   (cmd_i.ready),
    .rsp_ready_i   (rsp_o.ready),
    .rsp_valid_o   (rsp_o.valid),
    .log_points_i  (cfg_q.log_points),
    .ctl_o         (ctl),
    .coeff_raddr_o (coeff_raddr),
    .coeff_waddr_o (coeff_waddr),
    .tw_raddr_o    (tw_raddr),
    .tw_waddr_o    (tw_waddr)
  );

  nmbe_datapath #(.MaxPoints(MAX_POINTS)) u_datapath (
    .clk_i         (clk_i),
    .ctl_i         (ctl),
    .cfg_i         (cfg_q),
    .coeff_raddr_i (coeff_raddr),
    .coeff_waddr_i (coeff_waddr),
    .tw_raddr_i    (tw_raddr),
    .tw_waddr_i    (tw_waddr),
    .load_value_i  (cmd_i.value),
    .coefficient_o (coefficient)
  );

  assign rsp_o.coefficient = coefficient;

endmodule
